// ===== rtl/core/mmf_pkg.sv =====
package mmf_pkg;

  localparam logic [7:0] StatusBit = 8'h80;

  // Upper nibble codes of channel messages
  localparam logic [3:0] NibNoteOff   = 4'h8;
  localparam logic [3:0] NibNoteOn    = 4'h9;
  localparam logic [3:0] NibPolyPress = 4'hA;
  localparam logic [3:0] NibControl   = 4'hB;
  localparam logic [3:0] NibProgram   = 4'hC;
  localparam logic [3:0] NibChanPress = 4'hD;
  localparam logic [3:0] NibPitchBend = 4'hE;

  // Lower nibble codes of system messages
  localparam logic [3:0] SysExStart  = 4'h0;
  localparam logic [3:0] SysTimeCode = 4'h1;
  localparam logic [3:0] SysSongPos  = 4'h2;
  localparam logic [3:0] SysSongSel  = 4'h3;
  localparam logic [3:0] SysExEnd    = 4'h7;
  localparam logic [3:0] SysClock    = 4'h8;

  localparam logic [1:0] LenNone  = 2'd0;
  localparam logic [1:0] LenOne   = 2'd1;
  localparam logic [1:0] LenTwo   = 2'd2;
  localparam logic [1:0] LenThree = 2'd3;

  typedef struct packed {
    logic [7:0] status_byte;
    logic [6:0] first_data;
    logic [6:0] second_data;
    logic [1:0] byte_count;
    logic [7:0] source_id;
  } msg_t;

  function automatic logic [1:0] msg_length(input logic [7:0] b);
    logic [1:0] len;
    len = LenTwo;
    case (b[7:4])
      NibNoteOff, NibNoteOn, NibPolyPress, NibControl, NibPitchBend: len = LenThree;
      NibProgram, NibChanPress: len = LenTwo;
      default: begin
        case (b[3:0])
          SysTimeCode, SysSongSel: len = LenTwo;
          SysSongPos:              len = LenThree;
          SysExEnd, SysClock:      len = LenOne;
          SysExStart:              len = LenNone;
          default:                 len = LenTwo;
        endcase
      end
    endcase
    return len;
  endfunction

endpackage

// ===== rtl/core/mmf_rx_if.sv =====
interface mmf_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/core/mmf_msg_if.sv =====
interface mmf_msg_if;
  logic       valid;
  logic       ready;
  logic [7:0] status_byte;
  logic [6:0] first_data;
  logic [6:0] second_data;
  logic [1:0] byte_count;
  logic [7:0] source_id;

  modport source (output valid, output status_byte, output first_data, output second_data,
                  output byte_count, output source_id, input ready);
  modport sink   (input valid, input status_byte, input first_data, input second_data,
                  input byte_count, input source_id, output ready);
endinterface

// ===== rtl/core/mmf_framer.sv =====
module mmf_framer (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic [7:0]    byte_i,
  input  logic [7:0]    device_id_i,
  output logic          msg_valid_o,
  output mmf_pkg::msg_t msg_o
);

  logic [7:0] status_q, status_d;
  logic [6:0] data1_q, data1_d;
  logic [6:0] data2_q, data2_d;
  logic [1:0] pos_q, pos_d;
  logic [1:0] len_q, len_d;
  logic       taken;

  always_comb begin
    status_d = status_q;
    data1_d  = data1_q;
    data2_d  = data2_q;
    pos_d    = pos_q;
    len_d    = len_q;
    taken    = 1'b0;
    if (en_i) begin
      if ((byte_i & mmf_pkg::StatusBit) != 8'h00) begin
        // a status byte drops any partial message
        status_d = byte_i;
        pos_d    = 2'd1;
        len_d    = mmf_pkg::msg_length(byte_i);
        taken    = 1'b1;
      end else if (len_q != mmf_pkg::LenNone && pos_q != 2'd3) begin
        if (pos_q == 2'd2) begin
          data2_d = byte_i[6:0];
        end else begin
          data1_d = byte_i[6:0];
        end
        pos_d = pos_q + 2'd1;
        taken = 1'b1;
      end
    end

    msg_valid_o        = taken && len_d != mmf_pkg::LenNone && pos_d == len_d;
    msg_o.status_byte  = status_d;
    msg_o.first_data   = (len_d > mmf_pkg::LenOne) ? data1_d : 7'd0;
    msg_o.second_data  = (len_d > mmf_pkg::LenTwo) ? data2_d : 7'd0;
    msg_o.byte_count   = len_d;
    msg_o.source_id    = device_id_i;

    if (msg_valid_o) begin
      pos_d = 2'd0;
      len_d = mmf_pkg::LenNone;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= 8'h00;
      data1_q  <= 7'd0;
      data2_q  <= 7'd0;
      pos_q    <= 2'd0;
      len_q    <= mmf_pkg::LenNone;
    end else begin
      status_q <= status_d;
      data1_q  <= data1_d;
      data2_q  <= data2_d;
      pos_q    <= pos_d;
      len_q    <= len_d;
    end
  end

endmodule

// ===== rtl/core/midi_message_framer.sv =====
// MIDI message framer.
// rx_i carries raw MIDI bytes, one item per byte; msg_o carries one item per
// complete message (status byte, up to two data bytes, byte count, source id).
// cfg_we_i/cfg_wdata_i write the device id copied into every message; write it
// only while no byte is in flight.
// An accepted byte is captured in the input register and framed from there;
// a message it completes is registered in the output register and shown on msg_o.
// One byte is accepted per cycle while msg_o is not stalled; while a finished
// message waits on msg_o the input register can still take one more byte.
// Bytes that complete no message (data bytes, sysex contents, stray data)
// produce no item.
// Reset clears the framing state, the device id and the valid flags of both
// registers; no message is open afterwards.
// When the receiver holds msg_o.ready low the message holds, the byte in the
// input register waits, and rx_i.ready drops once that register is full.
module midi_message_framer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  mmf_rx_if.sink     rx_i,
  mmf_msg_if.source  msg_o
);

  logic          in_valid_q;
  logic [7:0]    in_byte_q;
  logic          out_valid_q;
  mmf_pkg::msg_t out_q;
  logic [7:0]    device_id_q;
  logic          out_free;
  logic          advance;
  logic          res_valid;
  mmf_pkg::msg_t res;

  assign out_free   = !out_valid_q || msg_o.ready;
  assign advance    = in_valid_q && out_free;
  assign rx_i.ready = !in_valid_q || out_free;

  mmf_framer u_framer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (advance),
    .byte_i      (in_byte_q),
    .device_id_i (device_id_q),
    .msg_valid_o (res_valid),
    .msg_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      device_id_q <= 8'h00;
    end else if (cfg_we_i) begin
      device_id_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_i.ready) begin
      in_valid_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.ready && rx_i.valid) begin
      in_byte_q <= rx_i.rx_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign msg_o.valid       = out_valid_q;
  assign msg_o.status_byte = out_q.status_byte;
  assign msg_o.first_data  = out_q.first_data;
  assign msg_o.second_data = out_q.second_data;
  assign msg_o.byte_count  = out_q.byte_count;
  assign msg_o.source_id   = out_q.source_id;

endmodule
